FILE: rtl/core/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
package lpfd_pkg;

  localparam int OP_W   = 8;
  localparam int LEN_W  = 6;
  localparam int IDX_W  = 5;
  localparam int DROP_W = 16;
  localparam int HDR_W  = OP_W + LEN_W;

  // slot numbers travel at full width; the ring holds at most 256 slots
  localparam int SLOT_MAX_W = 8;

  // command queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // decoder phases
  localparam logic [2:0] PH_OP   = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_PAY  = 3'd2;
  localparam logic [2:0] PH_CHK  = 3'd3;
  localparam logic [2:0] PH_LOCK = 3'd4;

  // pop command: the ring state as seen when the pop transaction was taken
  typedef struct packed {
    logic                  found;
    logic [SLOT_MAX_W-1:0] slot;
    logic [DROP_W-1:0]     drops;
    logic                  locked;
  } pop_cmd_t;

endpackage

FILE: rtl/core/lpfd_ifs.sv
// Valid/ready channel interfaces for the deframer's input and result streams.
interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface lpfd_out_if;
  logic        valid;
  logic        ready;
  logic        frame_found;
  logic [7:0]  frame_op;
  logic [5:0]  frame_length;
  logic [4:0]  byte_index;
  logic [7:0]  payload_byte;
  logic        last;
  logic [15:0] drop_count;
  logic        locked_error;

  modport source (output valid, output frame_found, output frame_op, output frame_length,
                  output byte_index, output payload_byte, output last, output drop_count,
                  output locked_error, input ready);
  modport sink   (input valid, input frame_found, input frame_op, input frame_length,
                  input byte_index, input payload_byte, input last, input drop_count,
                  input locked_error, output ready);
endinterface

FILE: rtl/core/lpfd_front.sv
// Front end: byte decoder, ring pointers, frame commit and pop classification.
module lpfd_front import lpfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 32,
  parameter int FRAME_SLOTS = 16,
  parameter int SLOT_W      = 4,
  parameter int AW          = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  lpfd_in_if.sink           in_bus,
  input  logic [SLOT_W-1:0] rd_done,
  output pop_cmd_t          cmd,
  output logic              cmd_push,
  input  logic              cmd_full,
  output logic              pay_we,
  output logic [AW-1:0]     pay_waddr,
  output logic [7:0]        pay_wdata,
  output logic              hdr_we,
  output logic [SLOT_W-1:0] hdr_waddr,
  output logic [HDR_W-1:0]  hdr_wdata
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);

  logic [2:0]        phase_r, phase_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [DROP_W-1:0] drop_r, drop_nxt;

  logic [SLOT_W-1:0] wr_slot_inc, rd_slot_inc;
  logic [SLOT_W:0]   dist_wr, dist_rd;
  logic              conflict_w, writes_slot, accept, byte_acc, pop_acc;

  assign wr_slot_inc = (wr_slot_r == LAST_SLOT) ? '0 : wr_slot_r + 1'b1;
  assign rd_slot_inc = (rd_slot_r == LAST_SLOT) ? '0 : rd_slot_r + 1'b1;

  // slots between rd_done and rd_slot are still being streamed by the back end
  always_comb begin
    dist_wr = {1'b0, wr_slot_r} - {1'b0, rd_done};
    if (wr_slot_r < rd_done) dist_wr = dist_wr + (SLOT_W+1)'(FRAME_SLOTS);
    dist_rd = {1'b0, rd_slot_r} - {1'b0, rd_done};
    if (rd_slot_r < rd_done) dist_rd = dist_rd + (SLOT_W+1)'(FRAME_SLOTS);
  end

  assign conflict_w  = dist_wr < dist_rd;
  assign writes_slot = (phase_r == PH_PAY) || (phase_r == PH_CHK);

  assign in_bus.ready = !cmd_full && !(writes_slot && conflict_w);
  assign accept       = in_bus.valid && in_bus.ready;
  assign byte_acc     = accept && !in_bus.kind;
  assign pop_acc      = accept && in_bus.kind;

  assign pay_waddr = AW'(wr_slot_r) * AW'(MAX_PAYLOAD) + AW'(cnt_r);
  assign pay_wdata = in_bus.rx_byte;
  assign hdr_waddr = wr_slot_r;
  assign hdr_wdata = {op_r, len_r};

  always_comb begin
    phase_nxt   = phase_r;
    op_nxt      = op_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    wr_slot_nxt = wr_slot_r;
    drop_nxt    = drop_r;
    pay_we      = 1'b0;
    hdr_we      = 1'b0;
    if (byte_acc) begin
      case (phase_r)
        PH_OP: begin
          op_nxt    = in_bus.rx_byte;
          len_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (in_bus.rx_byte > 8'(MAX_PAYLOAD)) begin
            phase_nxt = PH_LOCK;
          end else begin
            len_nxt   = in_bus.rx_byte[LEN_W-1:0];
            phase_nxt = (in_bus.rx_byte == 8'd0) ? PH_CHK : PH_PAY;
          end
        end
        PH_PAY: begin
          pay_we  = cnt_r < LEN_W'(MAX_PAYLOAD);
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_nxt >= len_r) phase_nxt = PH_CHK;
        end
        PH_CHK: begin
          if (wr_slot_inc == rd_slot_r) begin
            drop_nxt = drop_r + 1'b1;
          end else begin
            hdr_we      = 1'b1;
            wr_slot_nxt = wr_slot_inc;
          end
          phase_nxt = PH_OP;
        end
        default: begin
          // locked: bytes are swallowed
        end
      endcase
    end
  end

  // pops are resolved here so later bytes see the freed slot at once
  always_comb begin
    cmd.found   = rd_slot_r != wr_slot_r;
    cmd.slot    = SLOT_MAX_W'(rd_slot_r);
    cmd.drops   = drop_r;
    cmd.locked  = phase_r == PH_LOCK;
    cmd_push    = pop_acc;
    rd_slot_nxt = (pop_acc && cmd.found) ? rd_slot_inc : rd_slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_OP;
      op_r      <= '0;
      len_r     <= '0;
      cnt_r     <= '0;
      wr_slot_r <= '0;
      rd_slot_r <= '0;
      drop_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      op_r      <= op_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      wr_slot_r <= wr_slot_nxt;
      rd_slot_r <= rd_slot_nxt;
      drop_r    <= drop_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (pay_we || hdr_we) |-> !conflict_w)
    else $error("slot written while back end still reads it");

  a_commit_advances: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_we |=> (wr_slot_r != $past(wr_slot_r)) && (phase_r == PH_OP))
    else $error("frame commit did not advance write slot");
`endif

endmodule

FILE: rtl/core/lpfd_cmd_queue.sv
// Short FIFO of pop commands between the front and back ends.
module lpfd_cmd_queue import lpfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pop_cmd_t din,
  output logic     full,
  input  logic     pop,
  output pop_cmd_t dout,
  output logic     not_empty
);

  pop_cmd_t          entry_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, rptr_r;
  logic [QPTR_W:0]   count_r;

  assign full      = count_r == (QPTR_W+1)'(QDEPTH);
  assign not_empty = count_r != '0;
  assign dout      = entry_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("command queue overflow");
`endif

endmodule

FILE: rtl/core/lpfd_back.sv
// Back end: frame store memories and the pop sequencer that streams results.
module lpfd_back import lpfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 32,
  parameter int FRAME_SLOTS = 16,
  parameter int SLOT_W      = 4,
  parameter int AW          = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pop_cmd_t          cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  logic              pay_we,
  input  logic [AW-1:0]     pay_waddr,
  input  logic [7:0]        pay_wdata,
  input  logic              hdr_we,
  input  logic [SLOT_W-1:0] hdr_waddr,
  input  logic [HDR_W-1:0]  hdr_wdata,
  output logic [SLOT_W-1:0] rd_done,
  lpfd_out_if.source        out_bus
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_HDR  = 2'd1;
  localparam logic [1:0] B_PAY  = 2'd2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);

  // frame store
  logic [7:0]       pay_mem [FRAME_SLOTS*MAX_PAYLOAD];
  logic [HDR_W-1:0] hdr_mem [FRAME_SLOTS];
  logic [7:0]       pay_q_r;
  logic [HDR_W-1:0] hdr_q_r;
  logic             pay_re, hdr_re;
  logic [AW-1:0]    pay_raddr;
  logic [SLOT_W-1:0] hdr_raddr;

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [DROP_W-1:0] drops_r, drops_nxt;
  logic              locked_r, locked_nxt;
  logic [SLOT_W-1:0] done_r, done_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              o_found_r, o_found_nxt;
  logic [OP_W-1:0]   o_op_r, o_op_nxt;
  logic [LEN_W-1:0]  o_len_r, o_len_nxt;
  logic [IDX_W-1:0]  o_idx_r, o_idx_nxt;
  logic [7:0]        o_byte_r, o_byte_nxt;
  logic              o_last_r, o_last_nxt;
  logic [DROP_W-1:0] o_drops_r, o_drops_nxt;
  logic              o_locked_r, o_locked_nxt;

  logic              out_free;
  logic [SLOT_W-1:0] cmd_slot, slot_inc;
  logic [OP_W-1:0]   hdr_op;
  logic [LEN_W-1:0]  hdr_len;

  always_ff @(posedge clk) begin
    if (pay_we) pay_mem[pay_waddr] <= pay_wdata;
    if (pay_re) pay_q_r <= pay_mem[pay_raddr];
  end

  always_ff @(posedge clk) begin
    if (hdr_we) hdr_mem[hdr_waddr] <= hdr_wdata;
    if (hdr_re) hdr_q_r <= hdr_mem[hdr_raddr];
  end

  assign out_free = !out_valid_r || out_bus.ready;
  assign cmd_slot = cmd.slot[SLOT_W-1:0];
  assign slot_inc = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
  assign hdr_op   = hdr_q_r[HDR_W-1:LEN_W];
  assign hdr_len  = hdr_q_r[LEN_W-1:0];
  assign rd_done  = done_r;

  always_comb begin
    state_nxt    = state_r;
    slot_nxt     = slot_r;
    base_nxt     = base_r;
    op_nxt       = op_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    drops_nxt    = drops_r;
    locked_nxt   = locked_r;
    done_nxt     = done_r;
    cmd_pop      = 1'b0;
    hdr_re       = 1'b0;
    hdr_raddr    = cmd_slot;
    pay_re       = 1'b0;
    pay_raddr    = base_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    o_found_nxt  = o_found_r;
    o_op_nxt     = o_op_r;
    o_len_nxt    = o_len_r;
    o_idx_nxt    = o_idx_r;
    o_byte_nxt   = o_byte_r;
    o_last_nxt   = o_last_r;
    o_drops_nxt  = o_drops_r;
    o_locked_nxt = o_locked_r;

    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          if (cmd.found) begin
            cmd_pop    = 1'b1;
            hdr_re     = 1'b1;
            slot_nxt   = cmd_slot;
            base_nxt   = AW'(cmd_slot) * AW'(MAX_PAYLOAD);
            drops_nxt  = cmd.drops;
            locked_nxt = cmd.locked;
            state_nxt  = B_HDR;
          end else if (out_free) begin
            // empty ring: a single not-found result
            cmd_pop       = 1'b1;
            out_valid_nxt = 1'b1;
            o_found_nxt   = 1'b0;
            o_op_nxt      = '0;
            o_len_nxt     = '0;
            o_idx_nxt     = '0;
            o_byte_nxt    = '0;
            o_last_nxt    = 1'b1;
            o_drops_nxt   = cmd.drops;
            o_locked_nxt  = cmd.locked;
          end
        end
      end
      B_HDR: begin
        if (hdr_len == '0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            o_found_nxt   = 1'b1;
            o_op_nxt      = hdr_op;
            o_len_nxt     = '0;
            o_idx_nxt     = '0;
            o_byte_nxt    = '0;
            o_last_nxt    = 1'b1;
            o_drops_nxt   = drops_r;
            o_locked_nxt  = locked_r;
            done_nxt      = slot_inc;
            state_nxt     = B_IDLE;
          end
        end else begin
          pay_re    = 1'b1;
          pay_raddr = base_r;
          op_nxt    = hdr_op;
          len_nxt   = hdr_len;
          idx_nxt   = '0;
          state_nxt = B_PAY;
        end
      end
      B_PAY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_found_nxt   = 1'b1;
          o_op_nxt      = op_r;
          o_len_nxt     = len_r;
          o_idx_nxt     = idx_r[IDX_W-1:0];
          o_byte_nxt    = pay_q_r;
          o_last_nxt    = (idx_r + 1'b1) == len_r;
          o_drops_nxt   = drops_r;
          o_locked_nxt  = locked_r;
          if ((idx_r + 1'b1) == len_r) begin
            done_nxt  = slot_inc;
            state_nxt = B_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            pay_re    = 1'b1;
            pay_raddr = base_r + AW'(idx_nxt);
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    base_r     <= base_nxt;
    op_r       <= op_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    drops_r    <= drops_nxt;
    locked_r   <= locked_nxt;
    o_found_r  <= o_found_nxt;
    o_op_r     <= o_op_nxt;
    o_len_r    <= o_len_nxt;
    o_idx_r    <= o_idx_nxt;
    o_byte_r   <= o_byte_nxt;
    o_last_r   <= o_last_nxt;
    o_drops_r  <= o_drops_nxt;
    o_locked_r <= o_locked_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.frame_found  = o_found_r;
  assign out_bus.frame_op     = o_op_r;
  assign out_bus.frame_length = o_len_r;
  assign out_bus.byte_index   = o_idx_r;
  assign out_bus.payload_byte = o_byte_r;
  assign out_bus.last         = o_last_r;
  assign out_bus.drop_count   = o_drops_r;
  assign out_bus.locked_error = o_locked_r;

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_PAY) |-> (idx_r < len_r))
    else $error("payload index past frame length");

  a_found_reads_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_IDLE && cmd_pop && cmd.found) |=> (state_r == B_HDR))
    else $error("found pop did not fetch header");
`endif

endmodule

FILE: rtl/core/length_prefixed_frame_deframer_top.sv
// Top level of the length-prefixed frame deframer.
//
// Usage:
//   in_bus  : valid/ready channel. kind 0 carries a received byte in rx_byte,
//             kind 1 asks for the oldest queued frame. A transaction completes
//             when valid and ready are both high at a rising clk edge.
//   out_bus : valid/ready result channel. A pop yields one result per payload
//             byte (last marks the final one), or one result for an empty ring
//             or a zero-length frame.
// Flow:
//   Received bytes: one per cycle while in_bus.ready is high, no result.
//   Pops: queued up to four deep. The back end reads the frame header from
//   the registered frame store, then streams one payload byte per cycle while
//   the receiver takes results; an empty-ring pop yields its result directly.
// Reset (rst_n low, synchronous): decoder expects an op byte, ring empty,
//   drop counter zero. The frame store is not cleared; no pass is needed.
// Receiver stall: the result register holds, the back end waits, and the front
//   keeps taking bytes until the pop queue fills or a byte would land in a slot
//   whose frame is still being streamed out.
module length_prefixed_frame_deframer_top import lpfd_pkg::*; #(
  parameter int MAX_PAYLOAD = 32,
  parameter int FRAME_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  lpfd_in_if.sink    in_bus,
  lpfd_out_if.source out_bus
);

  // slot index and frame-store address widths
  localparam int SLOT_W = $clog2(FRAME_SLOTS);
  localparam int AW     = $clog2(FRAME_SLOTS * MAX_PAYLOAD);

  pop_cmd_t          cmd_in, cmd_out;
  logic              cmd_push, cmd_full, cmd_pop, cmd_valid;
  logic              pay_we, hdr_we;
  logic [AW-1:0]     pay_waddr;
  logic [7:0]        pay_wdata;
  logic [SLOT_W-1:0] hdr_waddr;
  logic [HDR_W-1:0]  hdr_wdata;
  logic [SLOT_W-1:0] rd_done;

  // front: decodes bytes, commits frames, resolves pops against the ring
  lpfd_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .FRAME_SLOTS (FRAME_SLOTS),
    .SLOT_W      (SLOT_W),
    .AW          (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .rd_done   (rd_done),
    .cmd       (cmd_in),
    .cmd_push  (cmd_push),
    .cmd_full  (cmd_full),
    .pay_we    (pay_we),
    .pay_waddr (pay_waddr),
    .pay_wdata (pay_wdata),
    .hdr_we    (hdr_we),
    .hdr_waddr (hdr_waddr),
    .hdr_wdata (hdr_wdata)
  );

  // pop commands decouple the byte path from result streaming
  lpfd_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .din       (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .dout      (cmd_out),
    .not_empty (cmd_valid)
  );

  // back: frame store and result sequencer
  lpfd_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .FRAME_SLOTS (FRAME_SLOTS),
    .SLOT_W      (SLOT_W),
    .AW          (AW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_out),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .pay_we    (pay_we),
    .pay_waddr (pay_waddr),
    .pay_wdata (pay_wdata),
    .hdr_we    (hdr_we),
    .hdr_waddr (hdr_waddr),
    .hdr_wdata (hdr_wdata),
    .rd_done   (rd_done),
    .out_bus   (out_bus)
  );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the length-prefixed frame deframer top level.
`timescale 1ns / 100ps

package deframer_tb_pkg;
  import lpfd_pkg::*;

  // input transaction kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef struct packed {
    logic        found;
    logic [7:0]  op;
    logic [5:0]  len;
    logic [4:0]  idx;
    logic [7:0]  data;
    logic        last;
    logic [15:0] drops;
    logic        locked;
  } frame_beat_t;

  // Tracks decoder and frame ring state; holds the beats each pop still owes.
  class deframer_scoreboard #(int MAXP = 32, int SLOTS = 16);
    logic [2:0]  phase;
    logic [7:0]  cur_op;
    logic [5:0]  cur_len;
    int unsigned pay_count;
    logic [7:0]  hdr_op [SLOTS];
    logic [5:0]  hdr_len [SLOTS];
    logic [7:0]  store [SLOTS][MAXP];
    int unsigned wr;
    int unsigned rd;
    logic [15:0] drops;
    frame_beat_t owed_beats[$];
    int unsigned errors;
    int unsigned beats_seen;

    function new();
      phase      = PH_OP;
      cur_op     = '0;
      cur_len    = '0;
      pay_count  = 0;
      wr         = 0;
      rd         = 0;
      drops      = '0;
      errors     = 0;
      beats_seen = 0;
    endfunction

    function void decode_byte(logic [7:0] b);
      case (phase)
        PH_OP: begin
          cur_op    = b;
          cur_len   = '0;
          pay_count = 0;
          phase     = PH_LEN;
        end
        PH_LEN: begin
          if (b > MAXP) begin
            phase = PH_LOCK;
          end else begin
            cur_len = b[5:0];
            phase   = (b == 8'd0) ? PH_CHK : PH_PAY;
          end
        end
        PH_PAY: begin
          // payload lands in the uncommitted slot directly
          if (pay_count < MAXP) store[wr][pay_count] = b;
          pay_count++;
          if (pay_count >= cur_len) phase = PH_CHK;
        end
        PH_CHK: begin
          if ((wr + 1) % SLOTS == rd) begin
            drops++;
          end else begin
            hdr_op[wr]  = cur_op;
            hdr_len[wr] = cur_len;
            wr          = (wr + 1) % SLOTS;
          end
          phase = PH_OP;
        end
        default: ;
      endcase
    endfunction

    function void pop_frame();
      frame_beat_t b;
      int unsigned n;
      b        = '0;
      b.drops  = drops;
      b.locked = (phase == PH_LOCK);
      b.last   = 1'b1;
      if (rd == wr) begin
        owed_beats.push_back(b);
        return;
      end
      b.found = 1'b1;
      b.op    = hdr_op[rd];
      n       = 32'(hdr_len[rd]);
      if (n > MAXP) n = MAXP;
      if (n == 0) begin
        owed_beats.push_back(b);
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          b.len  = n[5:0];
          b.idx  = i[4:0];
          b.data = store[rd][i];
          b.last = (i + 1 == n);
          owed_beats.push_back(b);
        end
      end
      rd = (rd + 1) % SLOTS;
    endfunction

    function void note_input(logic kind, logic [7:0] rx_byte);
      if (kind == KIND_POP) pop_frame();
      else decode_byte(rx_byte);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch at result %0d: %s got %0h want %0h", beats_seen, what, got, want);
      errors++;
    endtask

    task cmp_field(string what, int unsigned got, int unsigned want);
      if (got != want) report_mismatch(what, got, want);
    endtask

    task check_result(frame_beat_t got);
      frame_beat_t want;
      if (owed_beats.size() == 0) begin
        report_mismatch("unexpected result", 32'(got.data), 0);
      end else begin
        want = owed_beats.pop_front();
        cmp_field("frame_found", 32'(got.found), 32'(want.found));
        cmp_field("frame_op", 32'(got.op), 32'(want.op));
        cmp_field("frame_length", 32'(got.len), 32'(want.len));
        cmp_field("byte_index", 32'(got.idx), 32'(want.idx));
        cmp_field("payload_byte", 32'(got.data), 32'(want.data));
        cmp_field("last", 32'(got.last), 32'(want.last));
        cmp_field("drop_count", 32'(got.drops), 32'(want.drops));
        cmp_field("locked_error", 32'(got.locked), 32'(want.locked));
      end
      beats_seen++;
    endtask
  endclass
endpackage

module testbench;
  import lpfd_pkg::*;
  import deframer_tb_pkg::*;

  localparam int MAX_PAYLOAD  = 32;
  localparam int FRAME_SLOTS  = 16;
  localparam int RANDOM_ITEMS = 320;

  logic clk;
  logic rst_n;

  lpfd_in_if  in_bus ();
  lpfd_out_if out_bus ();

  length_prefixed_frame_deframer_top #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .FRAME_SLOTS(FRAME_SLOTS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  deframer_scoreboard #(MAX_PAYLOAD, FRAME_SLOTS) sb;

  // Percent chance per cycle that the sender holds off / the receiver stalls.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned sent = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs; well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Result side: every accepted transaction is checked against the oldest
  // expected beat, then ready is redrawn for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sb.check_result(frame_beat_t'{out_bus.frame_found, out_bus.frame_op,
                                    out_bus.frame_length, out_bus.byte_index,
                                    out_bus.payload_byte, out_bus.last,
                                    out_bus.drop_count, out_bus.locked_error});
    end
    out_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // One input transaction. Valid stays high between back-to-back items so it
  // is never dropped and raised in the same step.
  task automatic send_item(input logic kind, input logic [7:0] data);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_bus.valid   <= 1'b1;
    in_bus.kind    <= kind;
    in_bus.rx_byte <= data;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_input(kind, data);
    sent++;
  endtask

  // A received byte that must not lock the decoder: if it lands in the length
  // position it is folded into the legal range.
  task automatic send_byte(input logic [7:0] data);
    if (sb.phase == PH_LEN && data > MAX_PAYLOAD) data = 8'($urandom_range(MAX_PAYLOAD));
    send_item(KIND_BYTE, data);
  endtask

  task automatic send_pop();
    send_item(KIND_POP, 8'($urandom_range(255)));
  endtask

  // Well-formed frame; pops may be slipped in between payload bytes.
  task automatic send_frame(input logic [7:0] op, input int unsigned len,
                            input logic [7:0] chk, input int unsigned mid_pop_pct);
    send_byte(op);
    send_byte(len[7:0]);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < mid_pop_pct) send_pop();
      send_byte(8'($urandom_range(255)));
    end
    send_byte(chk);
  endtask

  // Walk the decoder back to the op position after garbage; short lengths keep
  // the filler brief.
  task automatic resync();
    while (sb.phase != PH_OP) begin
      if (sb.phase == PH_LEN) send_byte(8'($urandom_range(3)));
      else send_byte(8'($urandom_range(255)));
    end
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(3);
    if (r < 85) return $urandom_range(12, 4);
    if (r < 95) return $urandom_range(MAX_PAYLOAD - 1, 13);
    return MAX_PAYLOAD;
  endfunction

  initial begin
    int unsigned base;
    int unsigned pop_pct;
    int unsigned step;
    int unsigned roll;
    sb = new();
    in_bus.valid   <= 1'b0;
    in_bus.kind    <= KIND_BYTE;
    in_bus.rx_byte <= 8'h00;
    rst_n          <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, zero-length frame, byte extremes, pop while a frame
    // is still being assembled, then drain to empty again.
    send_item(KIND_POP, 8'hFF);
    send_frame(8'h00, 0, 8'h00, 0);
    send_item(KIND_POP, 8'h00);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_BYTE, 8'h01);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_BYTE, 8'hFF);
    send_item(KIND_BYTE, 8'h80);
    send_item(KIND_BYTE, 8'h02);
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'h7F);
    send_item(KIND_BYTE, 8'h55);
    send_item(KIND_BYTE, 8'h01);
    send_item(KIND_BYTE, 8'h01);
    send_pop();
    send_item(KIND_BYTE, 8'hAA);
    send_item(KIND_BYTE, 8'h00);
    send_pop();
    send_pop();
    send_pop();
    send_pop();

    // Random: cycles of ring-filling (drives drops), draining (empty pops) and
    // mixed traffic. Idling moves through four quarters: none, sender gaps,
    // receiver stalls, both.
    base = sent;
    step = 0;
    while (sent - base < RANDOM_ITEMS) begin
      case ((sent - base) * 4 / RANDOM_ITEMS)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 46; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 46; end
        default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
      endcase
      case ((step / 18) % 3)
        0: pop_pct = 3;
        1: pop_pct = 70;
        default: pop_pct = 30;
      endcase
      roll = $urandom_range(99);
      if (roll < pop_pct) begin
        send_pop();
      end else if (roll < pop_pct + 8) begin
        // garbage bytes, then back in step
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
        resync();
      end else begin
        send_frame(8'($urandom_range(255)), pick_len(), 8'($urandom_range(255)), 5);
      end
      step++;
    end

    // Lock: bring the decoder to the length position, give an oversize length,
    // show that later bytes are ignored and that pops still drain the ring.
    tx_idle_pct  = 9;
    rx_stall_pct = 9;
    while (sb.phase != PH_LEN) send_byte(8'($urandom_range(255)));
    send_item(KIND_BYTE, 8'($urandom_range(255, MAX_PAYLOAD + 1)));
    repeat (4) send_item(KIND_BYTE, 8'($urandom_range(255)));
    repeat (FRAME_SLOTS) begin
      send_pop();
      send_item(KIND_BYTE, 8'($urandom_range(255)));
    end

    in_bus.valid <= 1'b0;
    rx_stall_pct = 0;
    while (sb.owed_beats.size() != 0) @(posedge clk);
    // room for any stray result to show up
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
